// File: sv/csa_pkg.sv
package csa_pkg;

   // Pool geometry.
   localparam int SLOTS_PER_CHUNK = 16;
   localparam int CHUNK_COUNT     = 8;
   localparam int TOTAL_SLOTS     = SLOTS_PER_CHUNK * CHUNK_COUNT;

   // Derived widths.
   localparam int POS_W   = (SLOTS_PER_CHUNK > 1) ? $clog2(SLOTS_PER_CHUNK) : 1;
   localparam int CHUNK_W = (CHUNK_COUNT > 1) ? $clog2(CHUNK_COUNT) : 1;
   localparam int WALK_W  = $clog2(CHUNK_COUNT + 1);
   localparam int CNT_W   = $clog2(TOTAL_SLOTS + 1);
   localparam int CUSED_W = $clog2(SLOTS_PER_CHUNK + 1);
   localparam int WIDE_W  = (CNT_W > 8) ? CNT_W : 8;

   // Request modes.
   localparam logic [2:0] MODE_ALLOC   = 3'd0;
   localparam logic [2:0] MODE_RELEASE = 3'd1;
   localparam logic [2:0] MODE_CLEAR   = 3'd2;
   localparam logic [2:0] MODE_START   = 3'd3;
   localparam logic [2:0] MODE_NEXT    = 3'd4;

   // Response status codes.
   localparam logic [2:0] STAT_OK    = 3'd0;
   localparam logic [2:0] STAT_FULL  = 3'd1;
   localparam logic [2:0] STAT_FREE  = 3'd2;
   localparam logic [2:0] STAT_RANGE = 3'd3;
   localparam logic [2:0] STAT_END   = 3'd4;

   typedef logic [SLOTS_PER_CHUNK-1:0] row_type;
   typedef logic [POS_W-1:0]           pos_type;

   // Request to the chunk scanner: find the lowest bit equal to want at or above start.
   typedef struct packed {
      row_type row;
      pos_type start;
      logic    want;
   } scan_req_type;

   typedef struct packed {
      logic    hit;
      pos_type pos;
   } scan_rsp_type;

endpackage

// File: sv/csa_scan.sv
module csa_scan
   import csa_pkg::*;
(
   input  scan_req_type scan_req,
   output scan_rsp_type scan_rsp
);

   row_type cand;
   row_type masked;

   // Select the polarity and drop positions below the start point.
   always_comb begin
      cand = scan_req.want ? scan_req.row : ~scan_req.row;
      for (int i = 0; i < SLOTS_PER_CHUNK; i++) begin
         masked[i] = cand[i] && (POS_W'(i) >= scan_req.start);
      end
   end

   // Priority encode the lowest remaining candidate.
   always_comb begin
      scan_rsp.hit = |masked;
      scan_rsp.pos = '0;
      for (int i = SLOTS_PER_CHUNK - 1; i >= 0; i--) begin
         if (masked[i]) begin
            scan_rsp.pos = POS_W'(i);
         end
      end
   end

endmodule

// File: sv/chunked_slot_allocator.sv
// Slot allocator over CHUNK_COUNT chunks of SLOTS_PER_CHUNK slots (8 x 16 by default).
// A request is taken while the block is idle, and the block then works on it alone:
// allocate and release step through the chunks one per cycle, sharing a single base adder,
// and allocate and next share a single chunk scanner (allocate finishes at the first
// chunk with a free slot at or above its hint, release at the slot's chunk); next walks
// on from its cursor to the next used slot or the end of the pool, and clear, start and
// unused modes need no stepping. The result then sits in an output register, and the next
// request is taken as soon as the previous one has finished, even while its response is still stalled. Flags, hints
// and counts live in flip-flops that reset clears at once, so no clearing pass is needed.
module chunked_slot_allocator
   import csa_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [2:0] req_mode,
   input  logic [7:0] req_slot,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [6:0] rsp_slot_index,
   output logic [2:0] rsp_status,
   output logic [7:0] rsp_used_total
);

   typedef enum logic [4:0] {
      S_IDLE    = 5'b00001,
      S_ALLOC   = 5'b00010,
      S_RELEASE = 5'b00100,
      S_NEXT    = 5'b01000,
      S_MISC    = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   logic [2:0]         mode_ff, mode_in;
   logic [7:0]         slot_ff, slot_in;
   logic [CHUNK_W-1:0] chunk_ff, chunk_in;
   logic [CNT_W-1:0]   base_ff, base_in;
   logic [WALK_W-1:0]  walk_chunk_ff, walk_chunk_in;
   pos_type            walk_pos_ff, walk_pos_in;
   logic [CNT_W-1:0]   walk_base_ff, walk_base_in;
   row_type            flags_ff [CHUNK_COUNT];
   row_type            flags_in [CHUNK_COUNT];
   pos_type            hint_ff [CHUNK_COUNT];
   pos_type            hint_in [CHUNK_COUNT];
   logic [CUSED_W-1:0] cused_ff [CHUNK_COUNT];
   logic [CUSED_W-1:0] cused_in [CHUNK_COUNT];
   logic [CNT_W-1:0]   used_ff, used_in;

   logic               rsp_valid_ff;
   logic [6:0]         rsp_slot_index_ff;
   logic [2:0]         rsp_status_ff;
   logic [7:0]         rsp_used_total_ff;

   logic               out_free;
   logic               finish;
   logic [2:0]         fin_status;
   logic [CNT_W-1:0]   fin_index;

   logic [CHUNK_W-1:0] row_sel;
   scan_req_type       scan_req;
   scan_rsp_type       scan_rsp;
   logic [CNT_W-1:0]   next_base;
   logic [CNT_W-1:0]   walk_next_base;
   logic [WIDE_W-1:0]  slot_wide;
   pos_type            rel_pos;

   // The output register can take a new result when it is empty or being drained.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);

   // Shared chunk scanner: free slot from the hint on allocate, used slot on a walk.
   always_comb begin
      row_sel = (state_ff == S_NEXT) ? walk_chunk_ff[CHUNK_W-1:0] : chunk_ff;
      scan_req.row   = flags_ff[row_sel];
      scan_req.start = (state_ff == S_NEXT) ? walk_pos_ff : hint_ff[chunk_ff];
      scan_req.want  = (state_ff == S_NEXT);
   end

   csa_scan u_scan (
      .scan_req (scan_req),
      .scan_rsp (scan_rsp)
   );

   // Base adders for the chunk step and the slot offset inside a chunk.
   assign next_base      = base_ff + CNT_W'(SLOTS_PER_CHUNK);
   assign walk_next_base = walk_base_ff + CNT_W'(SLOTS_PER_CHUNK);
   assign slot_wide      = WIDE_W'(slot_ff);
   assign rel_pos        = POS_W'(slot_wide - WIDE_W'(base_ff));

   // Sequencer and pool state update.
   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      slot_in       = slot_ff;
      chunk_in      = chunk_ff;
      base_in       = base_ff;
      walk_chunk_in = walk_chunk_ff;
      walk_pos_in   = walk_pos_ff;
      walk_base_in  = walk_base_ff;
      flags_in      = flags_ff;
      hint_in       = hint_ff;
      cused_in      = cused_ff;
      used_in       = used_ff;
      finish        = 1'b0;
      fin_status    = STAT_OK;
      fin_index     = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               mode_in  = req_mode;
               slot_in  = req_slot;
               chunk_in = '0;
               base_in  = '0;
               unique case (req_mode)
                  MODE_ALLOC:   state_in = S_ALLOC;
                  MODE_RELEASE: state_in = S_RELEASE;
                  MODE_NEXT:    state_in = S_NEXT;
                  default:      state_in = S_MISC;
               endcase
            end
         end

         S_ALLOC: begin
            if (used_ff >= CNT_W'(TOTAL_SLOTS)) begin
               finish     = out_free;
               fin_status = STAT_FULL;
            end else if (scan_rsp.hit &&
                         (cused_ff[chunk_ff] != CUSED_W'(SLOTS_PER_CHUNK))) begin
               finish    = out_free;
               fin_index = base_ff + CNT_W'(scan_rsp.pos);
               if (out_free) begin
                  flags_in[chunk_ff][scan_rsp.pos] = 1'b1;
                  cused_in[chunk_ff] = cused_ff[chunk_ff] + 1'b1;
                  used_in            = used_ff + 1'b1;
                  hint_in[chunk_ff]  = scan_rsp.pos;
               end
            end else if (chunk_ff == CHUNK_W'(CHUNK_COUNT - 1)) begin
               finish     = out_free;
               fin_status = STAT_FULL;
            end else begin
               chunk_in = chunk_ff + 1'b1;
               base_in  = next_base;
            end
         end

         S_RELEASE: begin
            if (slot_wide >= WIDE_W'(TOTAL_SLOTS)) begin
               finish     = out_free;
               fin_status = STAT_RANGE;
            end else if (slot_wide < WIDE_W'(next_base)) begin
               finish = out_free;
               if (!flags_ff[chunk_ff][rel_pos]) begin
                  fin_status = STAT_FREE;
               end else if (out_free) begin
                  flags_in[chunk_ff][rel_pos] = 1'b0;
                  if (cused_ff[chunk_ff] != '0) begin
                     cused_in[chunk_ff] = cused_ff[chunk_ff] - 1'b1;
                  end
                  if (used_ff != '0) begin
                     used_in = used_ff - 1'b1;
                  end
                  if (rel_pos < hint_ff[chunk_ff]) begin
                     hint_in[chunk_ff] = rel_pos;
                  end
               end
            end else begin
               chunk_in = chunk_ff + 1'b1;
               base_in  = next_base;
            end
         end

         S_NEXT: begin
            if (walk_chunk_ff == WALK_W'(CHUNK_COUNT)) begin
               // Walk exhausted; the cursor stays parked past the last slot.
               finish     = out_free;
               fin_status = STAT_END;
            end else if (scan_rsp.hit) begin
               finish    = out_free;
               fin_index = walk_base_ff + CNT_W'(scan_rsp.pos);
               if (out_free) begin
                  if ((CUSED_W'(scan_rsp.pos) + 1'b1) == CUSED_W'(SLOTS_PER_CHUNK)) begin
                     walk_chunk_in = walk_chunk_ff + 1'b1;
                     walk_pos_in   = '0;
                     walk_base_in  = walk_next_base;
                  end else begin
                     walk_pos_in = scan_rsp.pos + 1'b1;
                  end
               end
            end else begin
               walk_chunk_in = walk_chunk_ff + 1'b1;
               walk_pos_in   = '0;
               walk_base_in  = walk_next_base;
            end
         end

         S_MISC: begin
            finish = out_free;
            if (out_free) begin
               unique case (mode_ff)
                  MODE_CLEAR: begin
                     for (int c = 0; c < CHUNK_COUNT; c++) begin
                        flags_in[c] = '0;
                        hint_in[c]  = '0;
                        cused_in[c] = '0;
                     end
                     used_in = '0;
                  end
                  MODE_START: begin
                     walk_chunk_in = '0;
                     walk_pos_in   = '0;
                     walk_base_in  = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end

         default: state_in = S_IDLE;
      endcase

      if (finish) begin
         state_in = S_IDLE;
      end
   end

   // Control and pool state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         chunk_ff      <= '0;
         base_ff       <= '0;
         walk_chunk_ff <= '0;
         walk_pos_ff   <= '0;
         walk_base_ff  <= '0;
         used_ff       <= '0;
         for (int c = 0; c < CHUNK_COUNT; c++) begin
            flags_ff[c] <= '0;
            hint_ff[c]  <= '0;
            cused_ff[c] <= '0;
         end
      end else begin
         state_ff      <= state_in;
         chunk_ff      <= chunk_in;
         base_ff       <= base_in;
         walk_chunk_ff <= walk_chunk_in;
         walk_pos_ff   <= walk_pos_in;
         walk_base_ff  <= walk_base_in;
         used_ff       <= used_in;
         flags_ff      <= flags_in;
         hint_ff       <= hint_in;
         cused_ff      <= cused_in;
      end
   end

   // Request payload captured at the transfer.
   always_ff @(posedge clock) begin
      mode_ff <= mode_in;
      slot_ff <= slot_in;
   end

   // Response register: filled when an operation finishes, emptied by a transfer.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         rsp_slot_index_ff <= 7'(fin_index);
         rsp_status_ff     <= fin_status;
         rsp_used_total_ff <= 8'(used_in);
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_slot_index = rsp_slot_index_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_used_total = rsp_used_total_ff;

   // The pool count never exceeds the number of slots.
   assert property (@(posedge clock) disable iff (reset)
      used_ff <= CNT_W'(TOTAL_SLOTS))
      else $error("used count exceeds pool size");

   // The chunk being scanned never counts more slots than it holds.
   assert property (@(posedge clock) disable iff (reset)
      cused_ff[chunk_ff] <= CUSED_W'(SLOTS_PER_CHUNK))
      else $error("chunk use count exceeds chunk size");

   // A parked walk cursor always sits at the start of the virtual end chunk.
   assert property (@(posedge clock) disable iff (reset)
      (walk_chunk_ff == WALK_W'(CHUNK_COUNT)) |->
         (walk_pos_ff == '0) && (walk_base_ff == CNT_W'(TOTAL_SLOTS)))
      else $error("walk cursor inconsistent at end");

   // Leaving a busy state always leaves a response behind.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) ##1 (state_ff == S_IDLE) |-> rsp_valid_ff)
      else $error("operation finished without a response");

endmodule

// File: verif/chunked_slot_allocator_test.sv
module chunked_slot_allocator_test;
   timeunit 1ns;
   timeprecision 1ps;

   import csa_pkg::*;

   localparam int         HALF_PERIOD_NS = 6;
   localparam int         CYCLE_LIMIT    = 200000;
   localparam int         MAX_REPORTS    = 10;
   localparam int         HOLD_CYCLES    = 300;
   localparam int         SETTLE_CYCLES  = 2 * CHUNK_COUNT + 4;
   localparam logic [2:0] MODE_SPARE_LO  = 3'd5;
   localparam logic [2:0] MODE_SPARE_HI  = 3'd7;

   typedef struct packed {
      logic [6:0] slot_index;
      logic [2:0] status;
      logic [7:0] used_total;
   } alloc_result_type;

   // Tracks the pool as the block should see it and queues the response that each
   // accepted request must produce.
   class slot_pool_scoreboard;
      bit               in_use[TOTAL_SLOTS];
      int unsigned      seek_hint[CHUNK_COUNT];
      int unsigned      chunk_fill[CHUNK_COUNT];
      int unsigned      busy_count;
      int unsigned      walk_pos;
      alloc_result_type awaited[$];
      int               mismatches;

      function new();
         empty_pool();
         walk_pos   = 0;
         mismatches = 0;
      endfunction

      function void empty_pool();
         foreach (in_use[i]) in_use[i] = 1'b0;
         foreach (seek_hint[i]) begin
            seek_hint[i]  = 0;
            chunk_fill[i] = 0;
         end
         busy_count = 0;
      endfunction

      // Applies one accepted request to the pool and queues its response.
      function void note_request(logic [2:0] mode, logic [7:0] slot);
         alloc_result_type r;
         bit               found;
         int unsigned      g;
         int unsigned      c;
         r        = '0;
         r.status = STAT_OK;
         case (mode)
            MODE_ALLOC: begin
               r.status = STAT_FULL;
               found    = 1'b0;
               if (busy_count < TOTAL_SLOTS) begin
                  for (int ch = 0; ch < CHUNK_COUNT && !found; ch++) begin
                     for (int s = seek_hint[ch]; s < SLOTS_PER_CHUNK && !found; s++) begin
                        g = ch * SLOTS_PER_CHUNK + s;
                        if (!in_use[g]) begin
                           in_use[g] = 1'b1;
                           chunk_fill[ch]++;
                           busy_count++;
                           seek_hint[ch] = s;
                           r.slot_index  = g[6:0];
                           r.status      = STAT_OK;
                           found         = 1'b1;
                        end
                     end
                  end
               end
            end
            MODE_RELEASE: begin
               if (slot >= TOTAL_SLOTS) begin
                  r.status = STAT_RANGE;
               end else if (!in_use[slot]) begin
                  r.status = STAT_FREE;
               end else begin
                  c            = slot / SLOTS_PER_CHUNK;
                  in_use[slot] = 1'b0;
                  if (chunk_fill[c] > 0) chunk_fill[c]--;
                  if (busy_count > 0) busy_count--;
                  if (slot % SLOTS_PER_CHUNK < seek_hint[c])
                     seek_hint[c] = slot % SLOTS_PER_CHUNK;
               end
            end
            // The walk cursor survives a clear, so a walk in progress continues.
            MODE_CLEAR: empty_pool();
            MODE_START: walk_pos = 0;
            MODE_NEXT: begin
               r.status = STAT_END;
               while (walk_pos < TOTAL_SLOTS && r.status != STAT_OK) begin
                  g = walk_pos;
                  walk_pos++;
                  if (in_use[g]) begin
                     r.status     = STAT_OK;
                     r.slot_index = g[6:0];
                  end
               end
            end
            default: ;
         endcase
         r.used_total = busy_count[7:0];
         awaited.push_back(r);
      endfunction

      // Compares one response transfer with the oldest queued response.
      function void check_result(logic [6:0] index, logic [2:0] status, logic [7:0] total);
         alloc_result_type want;
         if (awaited.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("Unexpected response: slot_index %0d status %0d used_total %0d",
                        index, status, total);
            return;
         end
         want = awaited.pop_front();
         if (index !== want.slot_index || status !== want.status ||
             total !== want.used_total) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("Mismatch (index/status/total): expected %0d/%0d/%0d, got %0d/%0d/%0d",
                        want.slot_index, want.status, want.used_total, index, status, total);
         end
      endfunction

      // Returns a slot that is in use, or any slot when the pool is empty.
      function logic [7:0] pick_busy_slot();
         int unsigned first;
         int unsigned g;
         first = $urandom_range(TOTAL_SLOTS - 1);
         for (int k = 0; k < TOTAL_SLOTS; k++) begin
            g = (first + k) % TOTAL_SLOTS;
            if (in_use[g]) return g[7:0];
         end
         return first[7:0];
      endfunction
   endclass

   logic       clock          = 1'b0;
   logic       reset          = 1'b1;
   logic       req_valid      = 1'b0;
   logic       req_stall;
   logic [2:0] req_mode       = MODE_ALLOC;
   logic [7:0] req_slot       = 8'd0;
   logic       rsp_valid;
   logic       rsp_stall      = 1'b0;
   logic [6:0] rsp_slot_index;
   logic [2:0] rsp_status;
   logic [7:0] rsp_used_total;

   int  send_idle_pct  = 0;
   int  recv_stall_pct = 0;
   bit  hold_request   = 1'b0;
   int  cycle_count    = 0;

   slot_pool_scoreboard pool = new();

   chunked_slot_allocator dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_mode       (req_mode),
      .req_slot       (req_slot),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_slot_index (rsp_slot_index),
      .rsp_status     (rsp_status),
      .rsp_used_total (rsp_used_total)
   );

   always #HALF_PERIOD_NS clock = ~clock;

   // Give up if the run does not finish in a sane number of cycles.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("** chunked_slot_allocator: FAILED **");
         $finish;
      end
   end

   // Response side: random stall, or one long hold-off on request.
   initial begin
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp_stall    = 1'b1;
            hold_request = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         rsp_stall = ($urandom_range(99) < recv_stall_pct);
      end
   end

   // Check every response transfer.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         pool.check_result(rsp_slot_index, rsp_status, rsp_used_total);
   end

   // Offers one request, with a random idle gap first, and returns at the falling
   // edge after its transfer. Valid stays high so a following request goes back to back.
   task automatic send_request(logic [2:0] mode, logic [7:0] slot);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         req_mode  = 3'($urandom);
         req_slot  = 8'($urandom);
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_mode  = mode;
      req_slot  = slot;
      do @(posedge clock); while (req_stall);
      pool.note_request(mode, slot);
      @(negedge clock);
   endtask

   // Drops valid and waits until every queued response has arrived.
   task automatic wait_drained();
      req_valid = 1'b0;
      while (pool.awaited.size() != 0) @(negedge clock);
   endtask

   // Random traffic, mostly allocations and releases of slots in use.
   task automatic send_mixed(int count, int clear_pct);
      int         pick;
      logic [2:0] mode;
      logic [7:0] slot;
      repeat (count) begin
         pick = $urandom_range(99);
         slot = 8'($urandom);
         if (pick < clear_pct) begin
            mode = MODE_CLEAR;
         end else if (pick < 45) begin
            mode = MODE_ALLOC;
         end else if (pick < 72) begin
            mode = MODE_RELEASE;
            slot = pool.pick_busy_slot();
         end else if (pick < 78) begin
            mode = MODE_RELEASE;
         end else if (pick < 82) begin
            mode = MODE_START;
         end else if (pick < 96) begin
            mode = MODE_NEXT;
         end else begin
            mode = 3'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
         end
         send_request(mode, slot);
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: walk over an empty pool, clear during a walk, hint lowering,
      // double free, out-of-range slots and the unused modes.
      send_request(MODE_NEXT, 8'd0);
      send_request(MODE_NEXT, 8'hFF);
      repeat (3) send_request(MODE_ALLOC, 8'd0);
      send_request(MODE_START, 8'd0);
      send_request(MODE_NEXT, 8'd0);
      send_request(MODE_CLEAR, 8'd0);
      send_request(MODE_NEXT, 8'd0);
      repeat (3) send_request(MODE_ALLOC, 8'hFF);
      send_request(MODE_RELEASE, 8'd1);
      send_request(MODE_ALLOC, 8'd0);
      send_request(MODE_RELEASE, 8'd1);
      send_request(MODE_RELEASE, 8'd1);
      send_request(MODE_RELEASE, 8'(TOTAL_SLOTS));
      send_request(MODE_RELEASE, 8'hFF);
      send_request(MODE_RELEASE, 8'(TOTAL_SLOTS - 1));
      send_request(MODE_RELEASE, 8'd0);
      for (int m = MODE_SPARE_LO; m <= MODE_SPARE_HI; m++)
         send_request(3'(m), 8'($urandom));
      wait_drained();

      // No idling, with one long response hold-off so the block backs up.
      hold_request = 1'b1;
      send_mixed(80, 3);
      wait_drained();

      // Sender idles often: fill the pool past full, walk part of it, then churn
      // releases and allocations across every chunk.
      send_idle_pct = 56;
      send_request(MODE_CLEAR, 8'($urandom));
      repeat (TOTAL_SLOTS + 3) send_request(MODE_ALLOC, 8'($urandom));
      send_request(MODE_START, 8'($urandom));
      repeat (20) send_request(MODE_NEXT, 8'($urandom));
      send_mixed(40, 0);
      wait_drained();

      // Receiver stalls often.
      send_idle_pct  = 0;
      recv_stall_pct = 56;
      send_mixed(80, 3);
      wait_drained();

      // Both sides idle a little.
      send_idle_pct  = 11;
      recv_stall_pct = 11;
      send_mixed(60, 3);
      wait_drained();

      repeat (SETTLE_CYCLES) @(negedge clock);
      if (pool.mismatches == 0 && pool.awaited.size() == 0)
         $display("** chunked_slot_allocator: PASSED **");
      else
         $display("** chunked_slot_allocator: FAILED **");
      $finish;
   end

endmodule

// File: files.f
sv/csa_pkg.sv
sv/csa_scan.sv
sv/chunked_slot_allocator.sv
verif/chunked_slot_allocator_test.sv
